/* src/address_region_table_macros.svh */
// ----------------------------------------------------------------------------
// address_region_table_macros
// Assertion macros used by the region table checker.
// ----------------------------------------------------------------------------
`ifndef ADDRESS_REGION_TABLE_MACROS_SVH
`define ADDRESS_REGION_TABLE_MACROS_SVH

// same-cycle implication
`define ART_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("address_region_table: same-cycle check failed");

// next-cycle implication
`define ART_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("address_region_table: next-cycle check failed");

`endif

/* src/art_pkg.sv */
// ----------------------------------------------------------------------------
// art_pkg
// Types and constants of the address region table.
// ----------------------------------------------------------------------------
package art_pkg;

   localparam int unsigned ADDR_W   = 32;
   localparam int unsigned ID_W     = 5;
   localparam int unsigned LIMIT_W  = 6;
   localparam int unsigned MCOUNT_W = 6;
   localparam int unsigned CMD_W    = 3;

   localparam logic [LIMIT_W-1:0] LIMIT_CAP = 6'd32;

   localparam logic [CMD_W-1:0] CMD_ADD   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_SORT  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_FIND  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_RANGE = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ADD,
      ST_SIMPLE,
      ST_FIND_RD,
      ST_FIND_CMP,
      ST_RANGE_RD,
      ST_RANGE_CMP,
      ST_SORT_NEXT,
      ST_SORT_KEY,
      ST_SORT_SCAN,
      ST_SORT_CMP
   } state_type;

   typedef enum logic [1:0] {
      RD_MID,
      RD_IDX,
      RD_JM1
   } rd_src_type;

   typedef enum logic [1:0] {
      WR_NEW,
      WR_KEY,
      WR_RD
   } wr_src_type;

   typedef enum logic [2:0] {
      PUSH_DONE,
      PUSH_FULL,
      PUSH_FIND_HIT,
      PUSH_RANGE_HIT,
      PUSH_COUNT
   } push_type;

   typedef struct packed {
      logic [ADDR_W-1:0] base;
      logic [ADDR_W-1:0] size;
      logic [ID_W-1:0]   id;
   } entry_type;

   typedef struct packed {
      logic       load_req;
      logic       rd_en;
      rd_src_type rd_src;
      logic       wr_en;
      wr_src_type wr_src;
      logic       add_commit;
      logic       clear_table;
      logic       lo_step;
      logic       hi_step;
      logic       idx_inc;
      logic       found_inc;
      logic       key_load;
      logic       j_dec;
      logic       set_sorted;
      logic       push;
      push_type   push_kind;
   } ctl_cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic             full;
      logic             table_empty;
      logic             sorted;
      logic             lo_lt_hi;
      logic             addr_below;
      logic             addr_past;
      logic             idx_lt_count;
      logic             scan_more;
      logic             range_match;
      logic             j_zero;
      logic             rd_gt_key;
      logic             out_free;
   } ctl_stat_type;

endpackage

/* src/art_ram.sv */
// ----------------------------------------------------------------------------
// art_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module art_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/art_ctrl.sv */
// ----------------------------------------------------------------------------
// art_ctrl
// Command sequencer: add, sort, binary search, range scan, clear.
// ----------------------------------------------------------------------------
module art_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic [art_pkg::CMD_W-1:0] req_cmd,
   output logic                      req_stall,
   input  art_pkg::ctl_stat_type     stat,
   output art_pkg::ctl_cmd_type      ctl
);

   art_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= art_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      ctl           = '0;
      ctl.rd_src    = art_pkg::RD_IDX;
      ctl.wr_src    = art_pkg::WR_NEW;
      ctl.push_kind = art_pkg::PUSH_DONE;
      req_stall     = (state_ff != art_pkg::ST_IDLE);
      case (state_ff)
         art_pkg::ST_IDLE: begin
            if (req_valid) begin
               ctl.load_req = 1'b1;
               case (req_cmd)
                  art_pkg::CMD_ADD:   state_in = art_pkg::ST_ADD;
                  art_pkg::CMD_SORT:  state_in = art_pkg::ST_SORT_NEXT;
                  art_pkg::CMD_FIND:  state_in = art_pkg::ST_FIND_RD;
                  art_pkg::CMD_RANGE: state_in = art_pkg::ST_RANGE_RD;
                  default:            state_in = art_pkg::ST_SIMPLE;
               endcase
            end
         end
         art_pkg::ST_ADD: begin
            if (stat.out_free) begin
               ctl.push = 1'b1;
               if (stat.full) begin
                  ctl.push_kind = art_pkg::PUSH_FULL;
               end else begin
                  ctl.wr_en      = 1'b1;
                  ctl.add_commit = 1'b1;
               end
               state_in = art_pkg::ST_IDLE;
            end
         end
         art_pkg::ST_SIMPLE: begin
            if (stat.out_free) begin
               ctl.push        = 1'b1;
               ctl.clear_table = (stat.cmd == art_pkg::CMD_CLEAR);
               state_in        = art_pkg::ST_IDLE;
            end
         end
         art_pkg::ST_FIND_RD: begin
            if (stat.sorted && stat.lo_lt_hi) begin
               ctl.rd_en  = 1'b1;
               ctl.rd_src = art_pkg::RD_MID;
               state_in   = art_pkg::ST_FIND_CMP;
            end else if (stat.out_free) begin
               ctl.push = 1'b1;
               state_in = art_pkg::ST_IDLE;
            end
         end
         art_pkg::ST_FIND_CMP: begin
            if (stat.addr_below) begin
               ctl.hi_step = 1'b1;
               state_in    = art_pkg::ST_FIND_RD;
            end else if (stat.addr_past) begin
               ctl.lo_step = 1'b1;
               state_in    = art_pkg::ST_FIND_RD;
            end else if (stat.out_free) begin
               ctl.push      = 1'b1;
               ctl.push_kind = art_pkg::PUSH_FIND_HIT;
               state_in      = art_pkg::ST_IDLE;
            end
         end
         art_pkg::ST_RANGE_RD: begin
            if (stat.scan_more) begin
               ctl.rd_en = 1'b1;
               state_in  = art_pkg::ST_RANGE_CMP;
            end else if (stat.out_free) begin
               ctl.push      = 1'b1;
               ctl.push_kind = art_pkg::PUSH_COUNT;
               state_in      = art_pkg::ST_IDLE;
            end
         end
         art_pkg::ST_RANGE_CMP: begin
            if (!stat.range_match) begin
               ctl.idx_inc = 1'b1;
               state_in    = art_pkg::ST_RANGE_RD;
            end else if (stat.out_free) begin
               ctl.push      = 1'b1;
               ctl.push_kind = art_pkg::PUSH_RANGE_HIT;
               ctl.found_inc = 1'b1;
               ctl.idx_inc   = 1'b1;
               state_in      = art_pkg::ST_RANGE_RD;
            end
         end
         art_pkg::ST_SORT_NEXT: begin
            if (stat.idx_lt_count) begin
               ctl.rd_en = 1'b1;
               state_in  = art_pkg::ST_SORT_KEY;
            end else if (stat.out_free) begin
               ctl.push       = 1'b1;
               ctl.set_sorted = !stat.table_empty;
               state_in       = art_pkg::ST_IDLE;
            end
         end
         art_pkg::ST_SORT_KEY: begin
            ctl.key_load = 1'b1;
            state_in     = art_pkg::ST_SORT_SCAN;
         end
         art_pkg::ST_SORT_SCAN: begin
            if (!stat.j_zero) begin
               ctl.rd_en  = 1'b1;
               ctl.rd_src = art_pkg::RD_JM1;
               state_in   = art_pkg::ST_SORT_CMP;
            end else begin
               ctl.wr_en   = 1'b1;
               ctl.wr_src  = art_pkg::WR_KEY;
               ctl.idx_inc = 1'b1;
               state_in    = art_pkg::ST_SORT_NEXT;
            end
         end
         art_pkg::ST_SORT_CMP: begin
            ctl.wr_en = 1'b1;
            if (stat.rd_gt_key) begin
               ctl.wr_src = art_pkg::WR_RD;
               ctl.j_dec  = 1'b1;
               state_in   = art_pkg::ST_SORT_SCAN;
            end else begin
               ctl.wr_src  = art_pkg::WR_KEY;
               ctl.idx_inc = 1'b1;
               state_in    = art_pkg::ST_SORT_NEXT;
            end
         end
         default: begin
            state_in = art_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

/* src/art_dpath.sv */
// ----------------------------------------------------------------------------
// art_dpath
// Region storage, table counters, search and scan pointers, result register.
// ----------------------------------------------------------------------------
module art_dpath #(
   parameter int MAX_REGIONS = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [art_pkg::CMD_W-1:0]        req_cmd,
   input  logic [art_pkg::ADDR_W-1:0]       req_region_base,
   input  logic [art_pkg::ADDR_W-1:0]       req_region_size,
   input  logic [art_pkg::ADDR_W-1:0]       req_query_address,
   input  logic [art_pkg::ADDR_W-1:0]       req_query_size,
   input  logic [art_pkg::LIMIT_W-1:0]      req_limit,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_status,
   output logic                             rsp_hit,
   output logic [art_pkg::ID_W-1:0]         rsp_region_id,
   output logic [art_pkg::ADDR_W-1:0]       rsp_match_base,
   output logic [art_pkg::ADDR_W-1:0]       rsp_match_size,
   output logic [art_pkg::MCOUNT_W-1:0]     rsp_match_count,
   output logic                             rsp_last,
   input  art_pkg::ctl_cmd_type             ctl,
   output art_pkg::ctl_stat_type            stat
);

   localparam int IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
   localparam int CW = $clog2(MAX_REGIONS + 1);
   localparam int EW = $bits(art_pkg::entry_type);

   logic [art_pkg::CMD_W-1:0]    cmd_ff;
   logic [art_pkg::ADDR_W-1:0]   base_ff, size_ff, qaddr_ff, qend_ff;
   logic [art_pkg::LIMIT_W-1:0]  lim_ff, lim_in, found_ff, found_in;
   logic [CW-1:0]                count_ff, count_in;
   logic [art_pkg::ID_W-1:0]     next_id_ff, next_id_in;
   logic                         sorted_ff, sorted_in;
   logic [CW-1:0]                lo_ff, lo_in, hi_ff, hi_in;
   logic [CW-1:0]                idx_ff, idx_in, j_ff, j_in;
   art_pkg::entry_type           key_ff, key_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         status_ff, status_in, hit_ff, hit_in, last_ff, last_in;
   art_pkg::entry_type           ent_ff, ent_in;
   logic [art_pkg::MCOUNT_W-1:0] mcount_ff, mcount_in;

   logic [CW:0]                  mid_sum;
   logic [CW-1:0]                mid, jm1;
   logic [IW-1:0]                rd_addr, wr_addr;
   art_pkg::entry_type           rd_ent, wr_ent, new_ent;
   logic [EW-1:0]                rd_bits;
   logic [art_pkg::ADDR_W-1:0]   rd_end;

   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid     = mid_sum[CW:1];
   assign jm1     = j_ff - CW'(1);
   assign rd_ent  = art_pkg::entry_type'(rd_bits);
   assign rd_end  = rd_ent.base + rd_ent.size;
   assign new_ent = '{base: base_ff, size: size_ff, id: next_id_ff};

   always_comb begin
      case (ctl.rd_src)
         art_pkg::RD_MID: rd_addr = mid[IW-1:0];
         art_pkg::RD_JM1: rd_addr = jm1[IW-1:0];
         default:         rd_addr = idx_ff[IW-1:0];
      endcase
      case (ctl.wr_src)
         art_pkg::WR_KEY: begin
            wr_addr = j_ff[IW-1:0];
            wr_ent  = key_ff;
         end
         art_pkg::WR_RD: begin
            wr_addr = j_ff[IW-1:0];
            wr_ent  = rd_ent;
         end
         default: begin
            wr_addr = count_ff[IW-1:0];
            wr_ent  = new_ent;
         end
      endcase
   end

   art_ram #(
      .WIDTH (EW),
      .DEPTH (MAX_REGIONS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ctl.wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_ent),
      .rd_en   (ctl.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_bits)
   );

   always_comb begin
      count_in   = count_ff;
      next_id_in = next_id_ff;
      sorted_in  = sorted_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      idx_in     = idx_ff;
      j_in       = j_ff;
      found_in   = found_ff;
      lim_in     = lim_ff;
      key_in     = key_ff;
      if (ctl.load_req) begin
         lo_in    = '0;
         hi_in    = count_ff;
         idx_in   = (req_cmd == art_pkg::CMD_SORT) ? CW'(1) : '0;
         found_in = '0;
         lim_in   = (req_limit > art_pkg::LIMIT_CAP) ? art_pkg::LIMIT_CAP : req_limit;
      end
      if (ctl.add_commit) begin
         count_in   = count_ff + CW'(1);
         next_id_in = next_id_ff + art_pkg::ID_W'(1);
         sorted_in  = 1'b0;
      end
      if (ctl.clear_table) begin
         count_in   = '0;
         next_id_in = '0;
         sorted_in  = 1'b0;
      end
      if (ctl.set_sorted) begin
         sorted_in = 1'b1;
      end
      if (ctl.lo_step) begin
         lo_in = mid + CW'(1);
      end
      if (ctl.hi_step) begin
         hi_in = mid;
      end
      if (ctl.idx_inc) begin
         idx_in = idx_ff + CW'(1);
      end
      if (ctl.found_inc) begin
         found_in = found_ff + art_pkg::LIMIT_W'(1);
      end
      if (ctl.key_load) begin
         key_in = rd_ent;
         j_in   = idx_ff;
      end
      if (ctl.j_dec) begin
         j_in = jm1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      status_in    = status_ff;
      hit_in       = hit_ff;
      last_in      = last_ff;
      ent_in       = ent_ff;
      mcount_in    = mcount_ff;
      if (ctl.push) begin
         rsp_valid_in = 1'b1;
         status_in    = 1'b0;
         hit_in       = 1'b0;
         last_in      = 1'b1;
         ent_in       = '0;
         mcount_in    = '0;
         case (ctl.push_kind)
            art_pkg::PUSH_FULL: begin
               status_in = 1'b1;
            end
            art_pkg::PUSH_FIND_HIT: begin
               hit_in = 1'b1;
               ent_in = rd_ent;
            end
            art_pkg::PUSH_RANGE_HIT: begin
               hit_in  = 1'b1;
               ent_in  = rd_ent;
               last_in = 1'b0;
            end
            art_pkg::PUSH_COUNT: begin
               mcount_in = found_ff;
            end
            default: begin
               last_in = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         next_id_ff   <= '0;
         sorted_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         next_id_ff   <= next_id_in;
         sorted_ff    <= sorted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_req) begin
         cmd_ff   <= req_cmd;
         base_ff  <= req_region_base;
         size_ff  <= req_region_size;
         qaddr_ff <= req_query_address;
         qend_ff  <= req_query_address + req_query_size;
      end
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      idx_ff    <= idx_in;
      j_ff      <= j_in;
      found_ff  <= found_in;
      lim_ff    <= lim_in;
      key_ff    <= key_in;
      status_ff <= status_in;
      hit_ff    <= hit_in;
      last_ff   <= last_in;
      ent_ff    <= ent_in;
      mcount_ff <= mcount_in;
   end

   always_comb begin
      stat.cmd          = cmd_ff;
      stat.full         = (count_ff >= CW'(MAX_REGIONS));
      stat.table_empty  = (count_ff == '0);
      stat.sorted       = sorted_ff;
      stat.lo_lt_hi     = (lo_ff < hi_ff);
      stat.addr_below   = (qaddr_ff < rd_ent.base);
      stat.addr_past    = (qaddr_ff >= rd_end);
      stat.idx_lt_count = (idx_ff < count_ff);
      stat.scan_more    = (idx_ff < count_ff) && (found_ff < lim_ff);
      stat.range_match  = (rd_ent.base < qend_ff) && (rd_end > qaddr_ff);
      stat.j_zero       = (j_ff == '0);
      stat.rd_gt_key    = (rd_ent.base > key_ff.base);
      stat.out_free     = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_hit         = hit_ff;
   assign rsp_region_id   = ent_ff.id;
   assign rsp_match_base  = ent_ff.base;
   assign rsp_match_size  = ent_ff.size;
   assign rsp_match_count = mcount_ff;
   assign rsp_last        = last_ff;

endmodule

/* src/address_region_table.sv */
// ----------------------------------------------------------------------------
// address_region_table
// Table of address regions with add, sort, find, range query and clear.
// ----------------------------------------------------------------------------
// One request is worked at a time; all entries sit in one RAM with one
// registered read port, and that port sets the timing. Find is a binary
// search that reads one entry per step. A range query scans the entries
// in order. Sort is an insertion sort. A result is held in the output
// register while the next request is accepted.
module address_region_table #(
   parameter int MAX_REGIONS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [art_pkg::CMD_W-1:0]    req_cmd,
   input  logic [art_pkg::ADDR_W-1:0]   req_region_base,
   input  logic [art_pkg::ADDR_W-1:0]   req_region_size,
   input  logic [art_pkg::ADDR_W-1:0]   req_query_address,
   input  logic [art_pkg::ADDR_W-1:0]   req_query_size,
   input  logic [art_pkg::LIMIT_W-1:0]  req_limit,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_status,
   output logic                         rsp_hit,
   output logic [art_pkg::ID_W-1:0]     rsp_region_id,
   output logic [art_pkg::ADDR_W-1:0]   rsp_match_base,
   output logic [art_pkg::ADDR_W-1:0]   rsp_match_size,
   output logic [art_pkg::MCOUNT_W-1:0] rsp_match_count,
   output logic                         rsp_last
);

   art_pkg::ctl_cmd_type  ctl;
   art_pkg::ctl_stat_type stat;

   art_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_stall (req_stall),
      .stat      (stat),
      .ctl       (ctl)
   );

   art_dpath #(
      .MAX_REGIONS (MAX_REGIONS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .req_cmd           (req_cmd),
      .req_region_base   (req_region_base),
      .req_region_size   (req_region_size),
      .req_query_address (req_query_address),
      .req_query_size    (req_query_size),
      .req_limit         (req_limit),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_hit           (rsp_hit),
      .rsp_region_id     (rsp_region_id),
      .rsp_match_base    (rsp_match_base),
      .rsp_match_size    (rsp_match_size),
      .rsp_match_count   (rsp_match_count),
      .rsp_last          (rsp_last),
      .ctl               (ctl),
      .stat              (stat)
   );

endmodule

/* src/art_checker.sv */
// ----------------------------------------------------------------------------
// art_checker
// Port-level checks of the address region table results.
// ----------------------------------------------------------------------------
`include "address_region_table_macros.svh"

module art_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic                         rsp_status,
   input logic                         rsp_hit,
   input logic [art_pkg::ADDR_W-1:0]   rsp_match_base,
   input logic [art_pkg::MCOUNT_W-1:0] rsp_match_count,
   input logic                         rsp_last
);

   `ART_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_match_base))
   `ART_ASSERT_NOW(a_mid_is_hit, rsp_valid && !rsp_last, rsp_hit)
   `ART_ASSERT_NOW(a_full_final, rsp_valid && rsp_status, rsp_last && !rsp_hit)
   `ART_ASSERT_NOW(a_hit_no_count, rsp_valid && rsp_hit, rsp_match_count == '0 && !rsp_status)

endmodule

bind address_region_table art_checker u_art_checker (.*);

/* test/address_region_table_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// address_region_table_tb
// Self-checking bench for the address region table. A directed table of
// requests covers the extremes and special cases, then random request
// streams with add/sort/find/query/clear mixes run under varying idle patterns.
// Every response is compared against a behavioral table model.
// ----------------------------------------------------------------------------
module address_region_table_tb;

   localparam int DEPTH = 32;
   localparam logic [2:0] CMD_UNUSED = 3'd5;
   localparam logic [2:0] CMD_BAD    = 3'd7;

   typedef struct packed {
      logic        status;
      logic        hit;
      logic [4:0]  id;
      logic [31:0] base;
      logic [31:0] size;
      logic [5:0]  count;
      logic        last;
   } answer_type;

   typedef struct {
      logic [2:0]  cmd;
      logic [31:0] rbase;
      logic [31:0] rsize;
      logic [31:0] qaddr;
      logic [31:0] qsize;
      logic [5:0]  lim;
      logic        typed;
      answer_type  want;
   } row_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [2:0]  req_cmd = 0;
   logic [31:0] req_region_base = 0, req_region_size = 0;
   logic [31:0] req_query_address = 0, req_query_size = 0;
   logic [5:0]  req_limit = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic rsp_status, rsp_hit, rsp_last;
   logic [4:0]  rsp_region_id;
   logic [31:0] rsp_match_base, rsp_match_size;
   logic [5:0]  rsp_match_count;

   address_region_table dut (.*);

   always #5 clock = ~clock;

   // model state
   logic [31:0] tbl_base [DEPTH];
   logic [31:0] tbl_size [DEPTH];
   logic [4:0]  tbl_id [DEPTH];
   int          tbl_count;
   logic        tbl_sorted;
   logic [4:0]  tbl_next;

   answer_type pending [$];
   int errors = 0, responses = 0, requests = 0;
   int send_idle = 0, recv_idle = 0;

   function automatic answer_type blank();
      answer_type a;
      a = '{default: 0};
      a.last = 1;
      return a;
   endfunction

   function automatic answer_type carry(int e);
      answer_type a;
      a = '{default: 0};
      a.hit = 1;
      a.id = tbl_id[e];
      a.base = tbl_base[e];
      a.size = tbl_size[e];
      return a;
   endfunction

   task automatic model_table(input row_type r);
      answer_type a;
      int lo, hi, mid, found, cap, i, j;
      logic [31:0] stop, kb, ks;
      logic [4:0] kd;
      a = blank();
      case (r.cmd)
         art_pkg::CMD_ADD: begin
            if (tbl_count >= DEPTH) a.status = 1;
            else begin
               tbl_base[tbl_count] = r.rbase;
               tbl_size[tbl_count] = r.rsize;
               tbl_id[tbl_count] = tbl_next;
               tbl_count++;
               tbl_next++;
               tbl_sorted = 0;
            end
            pending.push_back(a);
         end
         art_pkg::CMD_SORT: begin
            if (tbl_count != 0) begin
               for (i = 1; i < tbl_count; i++) begin
                  kb = tbl_base[i]; ks = tbl_size[i]; kd = tbl_id[i];
                  j = i;
                  while (j > 0 && tbl_base[j-1] > kb) begin
                     tbl_base[j] = tbl_base[j-1];
                     tbl_size[j] = tbl_size[j-1];
                     tbl_id[j] = tbl_id[j-1];
                     j--;
                  end
                  tbl_base[j] = kb; tbl_size[j] = ks; tbl_id[j] = kd;
               end
               tbl_sorted = 1;
            end
            pending.push_back(a);
         end
         art_pkg::CMD_FIND: begin
            lo = 0; hi = tbl_count;
            if (tbl_sorted && tbl_count != 0)
               while (lo < hi) begin
                  mid = lo + (hi - lo) / 2;
                  stop = tbl_base[mid] + tbl_size[mid];
                  if (r.qaddr < tbl_base[mid]) hi = mid;
                  else if (r.qaddr >= stop) lo = mid + 1;
                  else begin
                     a = carry(mid);
                     a.last = 1;
                     break;
                  end
               end
            pending.push_back(a);
         end
         art_pkg::CMD_RANGE: begin
            stop = r.qaddr + r.qsize;
            cap = (r.lim > 32) ? 32 : r.lim;
            found = 0;
            for (i = 0; i < tbl_count && found < cap; i++)
               if (tbl_base[i] < stop && 32'(tbl_base[i] + tbl_size[i]) > r.qaddr) begin
                  pending.push_back(carry(i));
                  found++;
               end
            a.count = 6'(found);
            pending.push_back(a);
         end
         art_pkg::CMD_CLEAR: begin
            tbl_count = 0; tbl_sorted = 0; tbl_next = 0;
            pending.push_back(a);
         end
         default: pending.push_back(a);
      endcase
   endtask

   task automatic send(input row_type r);
      while (send_idle > 0 && $urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_cmd <= r.cmd;
      req_region_base <= r.rbase;
      req_region_size <= r.rsize;
      req_query_address <= r.qaddr;
      req_query_size <= r.qsize;
      req_limit <= r.lim;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (r.typed) pending.push_back(r.want);
      else model_table(r);
      requests++;
   endtask

   // keep the model's state in step with typed rows too
   task automatic send_typed(input row_type r);
      int n;
      send(r);
      if (r.typed) begin
         void'(pending.pop_back());
         n = pending.size();
         model_table(r);
         if (pending.size() != n + 1 || pending[n] != r.want) begin
            $display("%0t typed row disagrees with model: expected %p actual %p",
                     $time, r.want, pending[n]);
            errors++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         answer_type got, exp;
         got = '{rsp_status, rsp_hit, rsp_region_id, rsp_match_base,
                 rsp_match_size, rsp_match_count, rsp_last};
         responses++;
         if (pending.size() == 0) begin
            $display("%0t unexpected response: expected none actual %p", $time, got);
            errors++;
         end else begin
            exp = pending.pop_front();
            if (got != exp) begin
               $display("%0t mismatch expected %p actual %p", $time, exp, got);
               errors++;
            end
         end
      end
      rsp_stall <= (recv_idle > 0) && ($urandom_range(99) < recv_idle);
   end

   function automatic row_type mk(logic [2:0] c, logic [31:0] b, logic [31:0] s,
                                  logic [31:0] qa, logic [31:0] qs, logic [5:0] l);
      row_type r;
      r = '{c, b, s, qa, qs, l, 1'b0, blank()};
      return r;
   endfunction

   function automatic row_type typed(row_type r, logic status);
      r.typed = 1;
      r.want.status = status;
      return r;
   endfunction

   function automatic row_type rand_row(int mode);
      row_type r;
      int pick;
      logic [31:0] near;
      near = $urandom_range(15) << 8;
      r = mk(art_pkg::CMD_ADD, $urandom, $urandom, $urandom, $urandom, 6'($urandom));
      pick = $urandom_range(99);
      if (mode == 1) begin
         r.rbase = $urandom_range(4095);
         r.rsize = $urandom_range(512);
         r.qaddr = $urandom_range(4095);
         r.qsize = $urandom_range(1024);
         r.lim = 6'($urandom_range(40));
      end
      if (pick < 40) r.cmd = art_pkg::CMD_ADD;
      else if (pick < 48) r.cmd = art_pkg::CMD_SORT;
      else if (pick < 75) r.cmd = art_pkg::CMD_FIND;
      else if (pick < 93) r.cmd = art_pkg::CMD_RANGE;
      else if (pick < 97) r.cmd = art_pkg::CMD_CLEAR;
      else r.cmd = 3'($urandom_range(5, 7));
      if (pick >= 48 && pick < 60 && mode == 1) r.qaddr = near;
      return r;
   endfunction

   row_type plan [$];
   int phase, k;

   initial begin
      #200_000_000;
      $display("FAIL");
      $finish;
   end

   initial begin
      tbl_count = 0; tbl_sorted = 0; tbl_next = 0;
      for (k = 0; k < DEPTH; k++) begin
         tbl_base[k] = 0; tbl_size[k] = 0; tbl_id[k] = 0;
      end
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed
      plan.push_back(typed(mk(art_pkg::CMD_FIND, 0, 0, 0, 0, 0), 0));
      plan.push_back(typed(mk(art_pkg::CMD_SORT, 0, 0, 0, 0, 0), 0));
      plan.push_back(mk(art_pkg::CMD_RANGE, 0, 0, 0, 32'hFFFF_FFFF, 63));
      plan.push_back(typed(mk(art_pkg::CMD_ADD, 32'hFFFF_FFF0, 32'h20, 0, 0, 0), 0));
      plan.push_back(typed(mk(art_pkg::CMD_ADD, 0, 32'hFFFF_FFFF, 0, 0, 0), 0));
      plan.push_back(typed(mk(art_pkg::CMD_ADD, 32'h100, 0, 0, 0, 0), 0));
      plan.push_back(typed(mk(art_pkg::CMD_ADD, 32'h100, 32'h10, 0, 0, 0), 0));
      plan.push_back(mk(art_pkg::CMD_FIND, 0, 0, 32'h100, 0, 0));
      plan.push_back(mk(art_pkg::CMD_RANGE, 0, 0, 0, 32'hFFFF_FFFF, 63));
      plan.push_back(mk(art_pkg::CMD_RANGE, 0, 0, 32'h100, 32'h8, 0));
      plan.push_back(mk(art_pkg::CMD_RANGE, 0, 0, 32'hFFFF_FFF8, 32'h10, 1));
      plan.push_back(typed(mk(art_pkg::CMD_SORT, 0, 0, 0, 0, 0), 0));
      plan.push_back(mk(art_pkg::CMD_FIND, 0, 0, 32'h105, 0, 0));
      plan.push_back(mk(art_pkg::CMD_FIND, 0, 0, 32'hFFFF_FFFF, 0, 0));
      plan.push_back(mk(art_pkg::CMD_FIND, 0, 0, 0, 0, 0));
      plan.push_back(typed(mk(CMD_BAD, '1, '1, '1, '1, '1), 0));
      plan.push_back(typed(mk(CMD_UNUSED, 0, 0, 0, 0, 0), 0));
      plan.push_back(typed(mk(art_pkg::CMD_CLEAR, 0, 0, 0, 0, 0), 0));
      for (k = 0; k < 32; k++)
         plan.push_back(typed(mk(art_pkg::CMD_ADD, k * 16, 8, 0, 0, 0), 0));
      plan.push_back(typed(mk(art_pkg::CMD_ADD, '1, '1, 0, 0, 0), 1));
      plan.push_back(mk(art_pkg::CMD_RANGE, 0, 0, 0, 32'hFFFF_FFFF, 40));
      plan.push_back(typed(mk(art_pkg::CMD_SORT, 0, 0, 0, 0, 0), 0));
      plan.push_back(mk(art_pkg::CMD_FIND, 0, 0, 32'h1F4, 0, 0));
      plan.push_back(typed(mk(art_pkg::CMD_CLEAR, 0, 0, 0, 0, 0), 0));
      foreach (plan[i]) send_typed(plan[i]);

      // random, three idle patterns
      for (phase = 0; phase < 3; phase++) begin
         send_idle = (phase == 0) ? 32 : (phase == 1) ? 55 : 0;
         recv_idle = (phase == 0) ? 55 : (phase == 1) ? 32 : 0;
         for (k = 0; k < 22; k++) send_typed(rand_row(($urandom_range(3) != 0) ? 1 : 0));
      end

      req_valid <= 0;
      recv_idle = 0;
      while (pending.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("Ran %0d requests and checked %0d responses, including full table,",
               requests, responses);
      $display("wrapping regions, unsorted finds and capped range queries.");
      if (errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end
endmodule

/* address_region_table.f */
+incdir+src
src/art_pkg.sv
src/art_ram.sv
src/art_ctrl.sv
src/art_dpath.sv
src/address_region_table.sv
src/art_checker.sv
test/address_region_table_tb.sv
